// File: src/key_touch_event_queue_top_defines.svh
// Assertion macros shared by the event queue RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef KEY_TOUCH_EVENT_QUEUE_TOP_DEFINES_SVH
`define KEY_TOUCH_EVENT_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define KTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ktq_pkg.sv
// Types, codes and reset constants for the key/touch event queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ktq_pkg;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int SUM_W   = 48;
	localparam int MCNT_W  = 32;
	localparam int FILL_W  = 6;

	typedef enum logic [2:0] {
		OP_KEY_DOWN = 3'd0,
		OP_KEY_UP   = 3'd1,
		OP_PEN_DOWN = 3'd2,
		OP_PEN_UP   = 3'd3,
		OP_PEN_MOVE = 3'd4,
		OP_TICK     = 3'd5,
		OP_POP      = 3'd6,
		OP_CLEAR    = 3'd7
	} op_t;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_KEY  = 2'd1;
	localparam logic [1:0] KIND_PEN  = 2'd2;

	localparam logic [2:0] T_DOWN   = 3'd0;
	localparam logic [2:0] T_UP     = 3'd1;
	localparam logic [2:0] T_LONG   = 3'd2;
	localparam logic [2:0] T_REPEAT = 3'd3;
	localparam logic [2:0] T_MOVE   = 3'd4;

	localparam logic [1:0] REG_LONG_PRESS = 2'd0;
	localparam logic [1:0] REG_REPEAT     = 2'd1;
	localparam logic [1:0] REG_JITTER     = 2'd2;

	localparam logic [15:0] LONG_PRESS_RST = 16'd800;
	localparam logic [15:0] REPEAT_RST     = 16'd400;
	localparam logic [7:0]  JITTER_RST     = 8'd4;
	// average used when no point has been seen is minus this
	localparam logic [16:0] NO_POINT_OFS   = 17'd10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  etype;
		logic [31:0] payload;
	} entry_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic rd_en;
		logic exec;
		logic clr_wr;
	} ktq_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
		logic clr_last;
	} ktq_stat_t;
endpackage
`default_nettype wire

// File: src/ktq_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module ktq_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [DW-1:0] dvs_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          qbit;
	logic [DW:0]   rem_sub;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[NW-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		qbit    = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// quotient bits shift in where dividend bits leave
			dvd_q <= {dvd_q[NW-2:0], qbit};
			rem_q <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

// File: src/ktq_dp.sv
// Datapath: config registers, entry ring, hold/repeat timer, pen average.
// Depends on ktq_pkg, ktq_div and key_touch_event_queue_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "key_touch_event_queue_top_defines.svh"
module ktq_dp #(
	parameter int QUEUE_DEPTH = ktq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ktq_pkg::ktq_cmd_t   cmd,
	output ktq_pkg::ktq_stat_t       st,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_addr,
	input  wire logic [15:0]         cfg_wdata,
	input  wire logic [2:0]          in_op,
	input  wire logic [31:0]         in_key,
	input  wire logic [15:0]         in_x,
	input  wire logic [15:0]         in_y,
	input  wire logic [31:0]         in_now,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic                     queued,
	output logic                     pop_valid,
	output logic [1:0]               ev_kind,
	output logic [2:0]               ev_type,
	output logic [31:0]              ev_key,
	output logic [15:0]              ev_x,
	output logic [15:0]              ev_y,
	output logic [ktq_pkg::FILL_W-1:0] fill
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = ktq_pkg::SUM_W;
	localparam int MW = ktq_pkg::MCNT_W;

	// config
	logic [15:0] lp_q, rp_ms_q;
	logic [7:0]  jit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q    <= ktq_pkg::LONG_PRESS_RST;
			rp_ms_q <= ktq_pkg::REPEAT_RST;
			jit_q   <= ktq_pkg::JITTER_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				ktq_pkg::REG_LONG_PRESS: lp_q    <= cfg_wdata;
				ktq_pkg::REG_REPEAT:     rp_ms_q <= cfg_wdata;
				ktq_pkg::REG_JITTER:     jit_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// latched input item
	ktq_pkg::op_t op_q;
	logic [31:0]  key_q, now_q;
	logic [15:0]  x_q, y_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= ktq_pkg::op_t'(in_op);
			key_q <= in_key;
			x_q   <= in_x;
			y_q   <= in_y;
			now_q <= in_now;
		end
	end

	// state
	logic [AW-1:0] wp_q, rdp_q, clr_q;
	logic [CW-1:0] cnt_q;
	logic          held_q, rep_q;
	logic [31:0]   lt_q;
	logic [SW-1:0] sx_q, sy_q;
	logic [MW-1:0] mc_q;

	// dividers run on the sums as they stand when the move arrives
	logic          dx_done, dy_done;
	logic [SW-1:0] qx, qy;

	ktq_div #(.NW(SW), .DW(MW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(sx_q), .divisor(mc_q), .done(dx_done), .quotient(qx)
	);
	ktq_div #(.NW(SW), .DW(MW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(sy_q), .divisor(mc_q), .done(dy_done), .quotient(qy)
	);

	// ring memory
	ktq_pkg::entry_t mem [QUEUE_DEPTH];
	ktq_pkg::entry_t rd_q;
	logic [AW-1:0]   prev_wp, rd_addr;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	always_comb begin
		prev_wp = (wp_q == '0) ? AW'(QUEUE_DEPTH - 1) : wp_q - 1'b1;
		rd_addr = (op_q == ktq_pkg::OP_POP) ? rdp_q : prev_wp;
	end

	// next-state logic for one item
	logic            out_valid_q;
	logic            stage;
	ktq_pkg::entry_t s;
	logic            held_n, rep_n;
	logic [31:0]     lt_n;
	logic [SW-1:0]   sx_n, sy_n;
	logic [MW-1:0]   mc_n;
	logic [AW-1:0]   wp_n, rdp_n;
	logic [CW-1:0]   cnt_n;
	logic            drop;
	logic            pop_ok;
	logic [SW:0]     hi_x, hi_y;

	always_comb begin
		stage  = 1'b0;
		s      = '0;
		held_n = held_q;
		rep_n  = rep_q;
		lt_n   = lt_q;
		sx_n   = sx_q;
		sy_n   = sy_q;
		mc_n   = mc_q;
		wp_n   = wp_q;
		rdp_n  = rdp_q;
		cnt_n  = cnt_q;
		pop_ok = 1'b0;
		hi_x   = (SW + 1)'(x_q) + (SW + 1)'(jit_q);
		hi_y   = (SW + 1)'(y_q) + (SW + 1)'(jit_q);
		if (mc_q == '0) begin
			drop = ((17'(x_q) + ktq_pkg::NO_POINT_OFS) <= 17'(jit_q))
				&& ((17'(y_q) + ktq_pkg::NO_POINT_OFS) <= 17'(jit_q));
		end else begin
			drop = ({1'b0, qx} <= hi_x) && (({1'b0, qx} + (SW + 1)'(jit_q)) >= (SW + 1)'(x_q))
				&& ({1'b0, qy} <= hi_y) && (({1'b0, qy} + (SW + 1)'(jit_q)) >= (SW + 1)'(y_q));
		end

		case (op_q)
			ktq_pkg::OP_POP: begin
				if (cnt_q != '0) begin
					pop_ok = 1'b1;
					cnt_n  = cnt_q - 1'b1;
					rdp_n  = next_idx(rdp_q);
				end
			end
			ktq_pkg::OP_CLEAR: begin
				wp_n  = '0;
				rdp_n = '0;
				cnt_n = '0;
			end
			default: begin
				case (op_q)
					ktq_pkg::OP_KEY_DOWN, ktq_pkg::OP_KEY_UP: begin
						held_n = (op_q == ktq_pkg::OP_KEY_DOWN);
						rep_n  = 1'b0;
						if (op_q == ktq_pkg::OP_KEY_DOWN) lt_n = now_q;
						s.kind    = ktq_pkg::KIND_KEY;
						s.etype   = (op_q == ktq_pkg::OP_KEY_DOWN) ? ktq_pkg::T_DOWN
							: ktq_pkg::T_UP;
						s.payload = key_q;
						stage     = 1'b1;
					end
					ktq_pkg::OP_PEN_DOWN: begin
						sx_n = SW'(x_q); sy_n = SW'(y_q); mc_n = MW'(1);
						held_n = 1'b1; rep_n = 1'b0; lt_n = now_q;
						s.kind = ktq_pkg::KIND_PEN; s.etype = ktq_pkg::T_DOWN;
						s.payload = {x_q, y_q};
						stage = 1'b1;
					end
					ktq_pkg::OP_PEN_UP: begin
						sx_n = '0; sy_n = '0; mc_n = '0;
						held_n = 1'b0; rep_n = 1'b0;
						s.kind = ktq_pkg::KIND_PEN; s.etype = ktq_pkg::T_UP;
						s.payload = {x_q, y_q};
						stage = 1'b1;
					end
					ktq_pkg::OP_PEN_MOVE: begin
						if (drop) begin
							sx_n = sx_q + SW'(x_q);
							sy_n = sy_q + SW'(y_q);
							mc_n = mc_q + 1'b1;
						end else begin
							sx_n = SW'(x_q); sy_n = SW'(y_q); mc_n = MW'(1);
							lt_n = now_q; held_n = 1'b1; rep_n = 1'b0;
							s.kind = ktq_pkg::KIND_PEN; s.etype = ktq_pkg::T_MOVE;
							s.payload = {x_q, y_q};
							stage = 1'b1;
						end
					end
					default: ;
				endcase
				// long press, then repeat; either replaces the staged entry
				if (held_n && ((now_q - lt_n) >= {16'd0, lp_q})) begin
					held_n = 1'b0;
					rep_n  = 1'b1;
					lt_n   = now_q;
					s.kind = (rd_q.kind == ktq_pkg::KIND_KEY) ? ktq_pkg::KIND_KEY
						: ktq_pkg::KIND_PEN;
					s.etype   = ktq_pkg::T_LONG;
					s.payload = rd_q.payload;
					stage     = 1'b1;
				end
				if (rep_n && ((now_q - lt_n) >= {16'd0, rp_ms_q})) begin
					lt_n = now_q;
					s.kind = (rd_q.kind == ktq_pkg::KIND_KEY) ? ktq_pkg::KIND_KEY
						: ktq_pkg::KIND_PEN;
					s.etype   = ktq_pkg::T_REPEAT;
					s.payload = rd_q.payload;
					stage     = 1'b1;
				end
				if (stage) begin
					wp_n = next_idx(wp_q);
					if (cnt_q >= CW'(QUEUE_DEPTH)) begin
						rdp_n = next_idx(rdp_q);
						cnt_n = CW'(QUEUE_DEPTH);
					end else begin
						cnt_n = cnt_q + 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) mem[clr_q] <= '0;
		else if (cmd.exec && stage) mem[wp_q] <= s;
		if (cmd.rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rdp_q  <= '0;
			clr_q  <= '0;
			cnt_q  <= '0;
			held_q <= 1'b0;
			rep_q  <= 1'b0;
			lt_q   <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			mc_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.exec) begin
				wp_q   <= wp_n;
				rdp_q  <= rdp_n;
				cnt_q  <= cnt_n;
				held_q <= held_n;
				rep_q  <= rep_n;
				lt_q   <= lt_n;
				sx_q   <= sx_n;
				sy_q   <= sy_n;
				mc_q   <= mc_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			queued    <= stage && (op_q != ktq_pkg::OP_POP) && (op_q != ktq_pkg::OP_CLEAR);
			pop_valid <= pop_ok;
			ev_kind   <= pop_ok ? rd_q.kind : ktq_pkg::KIND_NONE;
			ev_type   <= pop_ok ? rd_q.etype : 3'd0;
			ev_key    <= (pop_ok && rd_q.kind == ktq_pkg::KIND_KEY) ? rd_q.payload : 32'd0;
			ev_x      <= (pop_ok && rd_q.kind != ktq_pkg::KIND_KEY) ? rd_q.payload[31:16]
				: 16'd0;
			ev_y      <= (pop_ok && rd_q.kind != ktq_pkg::KIND_KEY) ? rd_q.payload[15:0]
				: 16'd0;
			fill      <= ktq_pkg::FILL_W'(cnt_n);
		end
	end

	assign out_valid   = out_valid_q;
	assign st.need_div = (in_op == ktq_pkg::OP_PEN_MOVE) && (mc_q != '0);
	assign st.div_done = dx_done && dy_done;
	assign st.out_free = !out_valid_q || out_ready;
	assign st.clr_last = (clr_q == AW'(QUEUE_DEPTH - 1));

	`KTQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(QUEUE_DEPTH), "entry count above depth")
	`KTQ_ASSERT_NEXT(a_exec_out, cmd.exec, out_valid_q, "result not registered after exec")
	`KTQ_ASSERT_NEXT(a_clear, cmd.exec && op_q == ktq_pkg::OP_CLEAR,
		cnt_q == '0 && wp_q == '0 && rdp_q == '0, "clear left ring non-empty")
endmodule
`default_nettype wire

// File: src/ktq_ctrl.sv
// Controller FSM: clearing pass, accept, divide wait, ring read, apply.
// Depends on ktq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ktq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ktq_pkg::ktq_stat_t st,
	output ktq_pkg::ktq_cmd_t       cmd
);
	typedef enum logic [4:0] {
		S_CLR  = 5'b00001,
		S_IDLE = 5'b00010,
		S_DIV  = 5'b00100,
		S_RD   = 5'b01000,
		S_EXEC = 5'b10000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		in_ready      = (state_q == S_IDLE);
		cmd.load      = in_valid && (state_q == S_IDLE);
		cmd.div_start = cmd.load && st.need_div;
		cmd.rd_en     = (state_q == S_RD);
		cmd.exec      = (state_q == S_EXEC) && st.out_free;
		cmd.clr_wr    = (state_q == S_CLR);
		state_n       = state_q;
		case (state_q)
			S_CLR:  if (st.clr_last) state_n = S_IDLE;
			S_IDLE: if (cmd.load) state_n = st.need_div ? S_DIV : S_RD;
			S_DIV:  if (st.div_done) state_n = S_RD;
			S_RD:   state_n = S_EXEC;
			S_EXEC: if (st.out_free) state_n = S_IDLE;
			default: state_n = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_n;
	end
endmodule
`default_nettype wire

// File: src/key_touch_event_queue_top.sv
// Top level of the key/touch event queue: stream ports, packing.
// Depends on ktq_pkg, ktq_ctrl, ktq_dp.
//
// channel   dir  tdata                                  tuser
// s_axis    in   key_code, pen_x, pen_y, now_ms (96b)   op (3b)
// m_axis    out  queued..fill (80b, see port)           ev_kind (2b)
// cfg       in   cfg_we / cfg_addr / cfg_wdata, no wait
//
// A pen move with samples goes accept, divide wait (48-step divider on the
// sums), ring read, apply; any other item goes accept, ring read, apply.
// After reset a clearing pass zeroes the ring;
// no transfer is accepted then, config writes are.
// A stalled output holds the apply step; no new item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module key_touch_event_queue_top #(
	parameter int QUEUE_DEPTH = ktq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// key_code[31:0], pen_x[47:32], pen_y[63:48], now_ms[95:64]
	input  wire logic [95:0] s_axis_tdata,
	// op[2:0]
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// queued[0], pop_valid[1], ev_type[4:2], ev_key[36:5], ev_x[52:37],
	// ev_y[68:53], fill[74:69], zero[79:75]
	output logic [79:0]      m_axis_tdata,
	// ev_kind[1:0]
	output logic [1:0]       m_axis_tuser
);
	ktq_pkg::ktq_cmd_t  cmd;
	ktq_pkg::ktq_stat_t st;
	logic        queued, pop_valid;
	logic [2:0]  ev_type;
	logic [31:0] ev_key;
	logic [15:0] ev_x, ev_y;
	logic [ktq_pkg::FILL_W-1:0] fill;

	ktq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .st(st), .cmd(cmd)
	);

	ktq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_op(s_axis_tuser), .in_key(s_axis_tdata[31:0]),
		.in_x(s_axis_tdata[47:32]), .in_y(s_axis_tdata[63:48]),
		.in_now(s_axis_tdata[95:64]),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
		.queued(queued), .pop_valid(pop_valid), .ev_kind(m_axis_tuser),
		.ev_type(ev_type), .ev_key(ev_key), .ev_x(ev_x), .ev_y(ev_y), .fill(fill)
	);

	assign m_axis_tdata = {5'd0, fill, ev_y, ev_x, ev_key, ev_type, pop_valid, queued};
endmodule
`default_nettype wire

// File: bench/key_touch_event_queue_checker.sv
// Checker for the key/touch event queue: watches config writes and both
// stream channels, predicts each result and compares it with what comes out.
// Depends on ktq_pkg.
`timescale 1ns / 1ps
module key_touch_event_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending_count
);
	localparam int DEPTH = ktq_pkg::QUEUE_DEPTH_DEF;

	typedef struct packed {
		logic        queued;
		logic        pop_valid;
		logic [1:0]  kind;
		logic [2:0]  etype;
		logic [31:0] key;
		logic [15:0] x;
		logic [15:0] y;
		logic [5:0]  fill;
	} event_result_t;

	event_result_t expected_q[$];

	// predicted block state
	logic [15:0] long_press_ms, repeat_ms;
	logic [7:0]  jitter_px;
	ktq_pkg::entry_t ring[DEPTH];
	int          wr_idx, rd_idx, depth_used;
	logic        held, repeating;
	logic [31:0] hold_start;
	logic [47:0] acc_x, acc_y;
	logic [31:0] sample_cnt;

	function automatic logic near_avg(longint v, longint avg);
		return v >= avg - longint'(jitter_px) && v <= avg + longint'(jitter_px);
	endfunction

	function automatic ktq_pkg::entry_t copy_prev(logic [2:0] t);
		ktq_pkg::entry_t src, e;
		src = ring[(wr_idx == 0) ? DEPTH - 1 : wr_idx - 1];
		e.kind = (src.kind == ktq_pkg::KIND_KEY) ? ktq_pkg::KIND_KEY : ktq_pkg::KIND_PEN;
		e.etype = t;
		e.payload = src.payload;
		return e;
	endfunction

	function automatic event_result_t queue_step(ktq_pkg::op_t op, logic [31:0] key,
			logic [15:0] px, logic [15:0] py, logic [31:0] now);
		event_result_t r;
		ktq_pkg::entry_t e;
		logic staged;
		longint ax, ay;
		r = '0;
		e = '0;
		staged = 1'b0;
		if (op == ktq_pkg::OP_POP) begin
			if (depth_used != 0) begin
				e = ring[rd_idx];
				r.pop_valid = 1'b1;
				r.kind = e.kind;
				r.etype = e.etype;
				if (e.kind == ktq_pkg::KIND_KEY)
					r.key = e.payload;
				else begin
					r.x = e.payload[31:16];
					r.y = e.payload[15:0];
				end
				depth_used--;
				rd_idx = (rd_idx + 1) % DEPTH;
			end
		end else if (op == ktq_pkg::OP_CLEAR) begin
			wr_idx = 0;
			rd_idx = 0;
			depth_used = 0;
		end else begin
			case (op)
				ktq_pkg::OP_KEY_DOWN, ktq_pkg::OP_KEY_UP: begin
					held = (op == ktq_pkg::OP_KEY_DOWN);
					repeating = 1'b0;
					if (op == ktq_pkg::OP_KEY_DOWN) hold_start = now;
					e = '{ktq_pkg::KIND_KEY,
						(op == ktq_pkg::OP_KEY_DOWN) ? ktq_pkg::T_DOWN : ktq_pkg::T_UP, key};
					staged = 1'b1;
				end
				ktq_pkg::OP_PEN_DOWN: begin
					acc_x = px; acc_y = py; sample_cnt = 1;
					held = 1'b1; repeating = 1'b0; hold_start = now;
					e = '{ktq_pkg::KIND_PEN, ktq_pkg::T_DOWN, {px, py}};
					staged = 1'b1;
				end
				ktq_pkg::OP_PEN_UP: begin
					acc_x = '0; acc_y = '0; sample_cnt = 0;
					held = 1'b0; repeating = 1'b0;
					e = '{ktq_pkg::KIND_PEN, ktq_pkg::T_UP, {px, py}};
					staged = 1'b1;
				end
				ktq_pkg::OP_PEN_MOVE: begin
					ax = -10;
					ay = -10;
					if (sample_cnt != 0) begin
						ax = longint'(64'(acc_x) / 64'(sample_cnt));
						ay = longint'(64'(acc_y) / 64'(sample_cnt));
					end
					if (near_avg(longint'(px), ax) && near_avg(longint'(py), ay)) begin
						acc_x = acc_x + 48'(px);
						acc_y = acc_y + 48'(py);
						sample_cnt = sample_cnt + 1;
					end else begin
						acc_x = px; acc_y = py; sample_cnt = 1;
						hold_start = now; held = 1'b1; repeating = 1'b0;
						e = '{ktq_pkg::KIND_PEN, ktq_pkg::T_MOVE, {px, py}};
						staged = 1'b1;
					end
				end
				default: ;
			endcase
			if (held && (now - hold_start) >= 32'(long_press_ms)) begin
				held = 1'b0;
				repeating = 1'b1;
				hold_start = now;
				e = copy_prev(ktq_pkg::T_LONG);
				staged = 1'b1;
			end
			if (repeating && (now - hold_start) >= 32'(repeat_ms)) begin
				hold_start = now;
				e = copy_prev(ktq_pkg::T_REPEAT);
				staged = 1'b1;
			end
			if (staged) begin
				ring[wr_idx] = e;
				wr_idx = (wr_idx + 1) % DEPTH;
				if (depth_used >= DEPTH)
					rd_idx = (rd_idx + 1) % DEPTH;
				else
					depth_used++;
				r.queued = 1'b1;
			end
		end
		r.fill = 6'(depth_used);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		event_result_t got, want;
		if (!arst_n) begin
			long_press_ms = ktq_pkg::LONG_PRESS_RST;
			repeat_ms = ktq_pkg::REPEAT_RST;
			jitter_px = ktq_pkg::JITTER_RST;
			foreach (ring[i]) ring[i] = '0;
			wr_idx = 0; rd_idx = 0; depth_used = 0;
			held = 1'b0; repeating = 1'b0; hold_start = '0;
			acc_x = '0; acc_y = '0; sample_cnt = '0;
			expected_q.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					ktq_pkg::REG_LONG_PRESS: long_press_ms = cfg_wdata;
					ktq_pkg::REG_REPEAT:     repeat_ms = cfg_wdata;
					ktq_pkg::REG_JITTER:     jitter_px = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tuser, m_axis_tdata[4:2],
					m_axis_tdata[36:5], m_axis_tdata[52:37], m_axis_tdata[68:53],
					m_axis_tdata[74:69]};
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer: %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want || m_axis_tdata[79:75] !== 5'd0) begin
						if (fail_count < 10)
							$display("result mismatch: expected %p, got %p", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(queue_step(ktq_pkg::op_t'(s_axis_tuser),
					s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tdata[63:48],
					s_axis_tdata[95:64]));
			pending_count <= expected_q.size();
		end
	end
endmodule

// File: bench/key_touch_event_queue_top_tb.sv
// Testbench top for the key/touch event queue: clock, reset, stimulus,
// receiver back-pressure and the verdict. Depends on ktq_pkg and the checker.
`timescale 1ns / 1ps
module key_touch_event_queue_top_tb;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid, s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid, m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	int          fail_count, pending_count;

	int          sent_items;
	logic        calm;       // no random idling on either side
	logic        hold_done;
	int          hold_left;
	logic [31:0] tnow;
	logic [15:0] cx, cy;

	key_touch_event_queue_top dut (.*);
	key_touch_event_queue_checker chk (.*);

	always #5 clk = ~clk;

	// receiver: random stalls, one long hold-off mid-run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent_items >= 500) begin
			m_axis_tready <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= 400;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
		end
	end

	task automatic send(input ktq_pkg::op_t op, input logic [31:0] key,
			input logic [15:0] px, input logic [15:0] py, input logic [31:0] now);
		if (!calm && $urandom_range(0, 99) < 22) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {now, py, px, key};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		sent_items++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int n_items, input int pop_pct);
		int sel;
		ktq_pkg::op_t op;
		logic [15:0] px, py;
		for (int i = 0; i < n_items; i++) begin
			sel = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 70)
				tnow += $urandom_range(0, 60);
			else if ($urandom_range(0, 99) < 97)
				tnow += $urandom_range(0, 1500);
			else
				tnow = $urandom;
			if (sel < pop_pct) op = ktq_pkg::OP_POP;
			else if (sel < pop_pct + 2) op = ktq_pkg::OP_CLEAR;
			else case ($urandom_range(0, 9))
				0, 1: op = ktq_pkg::OP_KEY_DOWN;
				2: op = ktq_pkg::OP_KEY_UP;
				3: op = ktq_pkg::OP_PEN_DOWN;
				4: op = ktq_pkg::OP_PEN_UP;
				5, 6, 7: op = ktq_pkg::OP_PEN_MOVE;
				default: op = ktq_pkg::OP_TICK;
			endcase
			if ($urandom_range(0, 9) == 0) begin
				cx = $urandom;
				cy = $urandom;
			end
			// mostly small wander around the current pen position
			px = ($urandom_range(0, 7) == 0) ? 16'($urandom)
				: cx + 16'($urandom_range(0, 12)) - 16'd6;
			py = ($urandom_range(0, 7) == 0) ? 16'($urandom)
				: cy + 16'($urandom_range(0, 12)) - 16'd6;
			send(op, $urandom, px, py, tnow);
			// halfway through a phase with over 25 percent pops, the sender waits for every result
			if (i == n_items / 2 && pop_pct > 25) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_count != 0) @(posedge clk);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		sent_items = 0;
		calm = 1'b0;
		tnow = 32'd1000;
		cx = 16'd300;
		cy = 16'd200;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: long press and repeat at reset timing, pops, pen filter, wrap
		send(ktq_pkg::OP_POP, 32'h0, 16'h0, 16'h0, tnow);
		send(ktq_pkg::OP_KEY_DOWN, 32'h0, 16'h0, 16'h0, tnow);
		send(ktq_pkg::OP_TICK, 32'h0, 16'h0, 16'h0, tnow + 799);
		send(ktq_pkg::OP_TICK, 32'h0, 16'h0, 16'h0, tnow + 800);
		send(ktq_pkg::OP_TICK, 32'h0, 16'h0, 16'h0, tnow + 1199);
		send(ktq_pkg::OP_TICK, 32'h0, 16'h0, 16'h0, tnow + 1200);
		send(ktq_pkg::OP_KEY_UP, 32'hFFFF_FFFF, 16'h0, 16'h0, tnow + 1300);
		send(ktq_pkg::OP_PEN_DOWN, 32'h0, 16'h0, 16'h0, tnow + 1400);
		send(ktq_pkg::OP_PEN_MOVE, 32'h0, 16'd2, 16'd3, tnow + 1410);
		send(ktq_pkg::OP_PEN_MOVE, 32'h0, 16'hFFFF, 16'hFFFF, tnow + 1420);
		send(ktq_pkg::OP_PEN_UP, 32'h0, 16'hFFFF, 16'h0, tnow + 1430);
		send(ktq_pkg::OP_PEN_MOVE, 32'h0, 16'h0, 16'h0, tnow + 1440);
		repeat (9) send(ktq_pkg::OP_POP, 32'h0, 16'h0, 16'h0, tnow + 1450);
		send(ktq_pkg::OP_CLEAR, 32'h0, 16'h0, 16'h0, tnow + 1460);
		send(ktq_pkg::OP_POP, 32'h0, 16'h0, 16'h0, tnow + 1470);
		send(ktq_pkg::OP_KEY_DOWN, 32'hA5A5_5A5A, 16'h0, 16'h0, 32'hFFFF_FF00);
		send(ktq_pkg::OP_TICK, 32'h0, 16'h0, 16'h0, 32'h0000_0200);
		send(ktq_pkg::OP_TICK, 32'h0, 16'h0, 16'h0, 32'h0000_0220);
		tnow = 32'h0000_0300;
		drain();

		// every register at its low extreme; few pops so the ring wraps
		write_reg(ktq_pkg::REG_LONG_PRESS, 16'd0);
		write_reg(ktq_pkg::REG_REPEAT, 16'd0);
		write_reg(ktq_pkg::REG_JITTER, 16'd0);
		random_phase(180, 8);
		drain();

		// no-move-sample average of minus ten reachable with a wide window
		write_reg(ktq_pkg::REG_LONG_PRESS, 16'hFFFF);
		write_reg(ktq_pkg::REG_REPEAT, 16'hFFFF);
		write_reg(ktq_pkg::REG_JITTER, 16'h00FF);
		random_phase(180, 30);
		drain();

		write_reg(ktq_pkg::REG_LONG_PRESS, 16'd120);
		write_reg(ktq_pkg::REG_REPEAT, 16'd45);
		write_reg(ktq_pkg::REG_JITTER, 16'd6);
		calm = 1'b1;
		random_phase(120, 30);
		calm = 1'b0;
		random_phase(300, 30);
		drain();

		if (fail_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
